### rtl/core/lmcd_pkg.sv
// shared types and constants for the led matrix chain frame driver
`timescale 1ns / 1ps
package lmcd_pkg;

  localparam int ROWS_PER_CHIP   = 8;
  localparam int MAX_CHIPS_DEF   = 8;
  localparam int QUEUE_DEPTH     = 2;
  localparam logic [3:0] DEV_COUNT_RESET = 4'd8;

  localparam logic [2:0] CMD_LED       = 3'd0;
  localparam logic [2:0] CMD_ROW       = 3'd1;
  localparam logic [2:0] CMD_COLUMN    = 3'd2;
  localparam logic [2:0] CMD_CLEAR     = 3'd3;
  localparam logic [2:0] CMD_SHUTDOWN  = 3'd4;
  localparam logic [2:0] CMD_INTENSITY = 3'd5;
  localparam logic [2:0] CMD_SCANLIMIT = 3'd6;
  localparam logic [2:0] CMD_RAW       = 3'd7;

  localparam logic [3:0] REG_INTENSITY = 4'd10;
  localparam logic [3:0] REG_SCANLIMIT = 4'd11;
  localparam logic [3:0] REG_SHUTDOWN  = 4'd12;
  localparam logic [7:0] MAX_INTENSITY = 8'd15;
  localparam logic [7:0] MAX_SCANLIMIT = 8'd7;
  localparam logic [7:0] LED_MASK_MSB  = 8'h80;

  typedef struct packed {
    logic [2:0] command;
    logic [2:0] device;
    logic [2:0] line_index;
    logic [2:0] column_index;
    logic [7:0] value;
    logic [3:0] register_code;
  } in_word_t;

  typedef struct packed {
    logic [15:0] chain_word;
    logic        frame_end;
    logic        last;
  } out_word_t;

  typedef enum logic [1:0] {
    OP_LED   = 2'd0,
    OP_ROW   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_PLAIN = 2'd3
  } job_op_t;

  typedef struct packed {
    job_op_t    op;
    logic       multi;
    logic [2:0] device;
    logic [2:0] line;
    logic [2:0] col;
    logic [3:0] reg_code;
    logic [7:0] data;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

### rtl/core/lmcd_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module lmcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/lmcd_front.sv
// command decode and range checks ahead of the job queue
`timescale 1ns / 1ps
module lmcd_front #(
  parameter int CNT_W = 4
) (
  input  lmcd_pkg::in_word_t  in_data,
  input  logic                start,
  input  logic [CNT_W-1:0]    chain_len,
  input  lmcd_pkg::q_status_t q_status,
  output logic                busy,
  output logic                push,
  output lmcd_pkg::job_t      job
);

  localparam int CMP_W = (CNT_W > 3) ? CNT_W : 3;

  logic             ok;
  logic             in_chain;
  logic [CMP_W-1:0] dev_ext;
  logic [CMP_W-1:0] len_ext;

  assign dev_ext  = CMP_W'(in_data.device);
  assign len_ext  = CMP_W'(chain_len);
  assign in_chain = dev_ext < len_ext;

  always_comb begin
    ok           = in_chain;
    job.op       = lmcd_pkg::OP_PLAIN;
    job.multi    = 1'b0;
    job.device   = in_data.device;
    job.line     = in_data.line_index;
    job.col      = in_data.column_index;
    job.reg_code = in_data.register_code;
    job.data     = in_data.value;
    unique case (in_data.command)
      lmcd_pkg::CMD_LED: begin
        job.op = lmcd_pkg::OP_LED;
      end
      lmcd_pkg::CMD_ROW: begin
        job.op = lmcd_pkg::OP_ROW;
      end
      lmcd_pkg::CMD_COLUMN: begin
        job.op    = lmcd_pkg::OP_LED;
        job.multi = 1'b1;
        job.col   = in_data.line_index;
      end
      lmcd_pkg::CMD_CLEAR: begin
        job.op    = lmcd_pkg::OP_CLEAR;
        job.multi = 1'b1;
      end
      lmcd_pkg::CMD_SHUTDOWN: begin
        job.reg_code = lmcd_pkg::REG_SHUTDOWN;
        job.data     = (in_data.value != 8'd0) ? 8'd0 : 8'd1;
      end
      lmcd_pkg::CMD_INTENSITY: begin
        job.reg_code = lmcd_pkg::REG_INTENSITY;
        ok           = in_chain && (in_data.value <= lmcd_pkg::MAX_INTENSITY);
      end
      lmcd_pkg::CMD_SCANLIMIT: begin
        job.reg_code = lmcd_pkg::REG_SCANLIMIT;
        ok           = in_chain && (in_data.value <= lmcd_pkg::MAX_SCANLIMIT);
      end
      lmcd_pkg::CMD_RAW: begin
        job.reg_code = in_data.register_code;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  assign busy = q_status.full;
  assign push = start && !q_status.full && ok;

endmodule

### rtl/core/lmcd_queue.sv
// short job queue between decode and frame engine
`timescale 1ns / 1ps
module lmcd_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  lmcd_pkg::job_t      push_job,
  input  logic                pop,
  output lmcd_pkg::job_t      pop_job,
  output lmcd_pkg::q_status_t q_status
);

  localparam int DEPTH = lmcd_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lmcd_pkg::job_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic do_push, do_pop;

  assign q_status.full  = (count_r == CNT_W'(DEPTH));
  assign q_status.empty = (count_r == '0);
  assign do_push = push && !q_status.full;
  assign do_pop  = pop && !q_status.empty;
  assign pop_job = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

### rtl/core/lmcd_back.sv
// frame engine: shadow row update and word-by-word frame output
`timescale 1ns / 1ps
module lmcd_back #(
  parameter int MAX_CHIPS = lmcd_pkg::MAX_CHIPS_DEF,
  parameter int CNT_W     = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [CNT_W-1:0]    chain_len,
  input  lmcd_pkg::q_status_t q_status,
  input  lmcd_pkg::job_t      q_job,
  output logic                pop,
  output logic                out_valid,
  output lmcd_pkg::out_word_t out_data
);

  localparam int DEPTH  = MAX_CHIPS * lmcd_pkg::ROWS_PER_CHIP;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CMP_W  = (CNT_W > 3) ? CNT_W : 3;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_MERGE = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  lmcd_pkg::job_t      job_r;
  logic [2:0]          frame_r, frame_nxt;
  logic [CNT_W-1:0]    chip_r, chip_nxt;
  logic [15:0]         word_r;
  logic [DEPTH-1:0]    valid_r;
  logic                rd_valid_r;
  logic                out_valid_r;
  lmcd_pkg::out_word_t out_data_r;

  logic [2:0]          row;
  logic [ADDR_W+5:0]   addr_wide;
  logic [ADDR_W-1:0]   addr;
  logic [7:0]          ram_rdata;
  logic [7:0]          old_row;
  logic [7:0]          mask;
  logic                led_on;
  logic [7:0]          new_data;
  logic [3:0]          new_reg;
  logic                ram_we;
  logic                final_frame;
  logic                chip_hit;

  assign row       = job_r.multi ? frame_r : job_r.line;
  assign addr_wide = {{ADDR_W{1'b0}}, job_r.device, row};
  assign addr      = addr_wide[ADDR_W-1:0];
  assign old_row   = rd_valid_r ? ram_rdata : 8'd0;
  assign mask      = lmcd_pkg::LED_MASK_MSB >> job_r.col;
  assign led_on    = job_r.multi ? job_r.data[3'd7 - frame_r] : job_r.data[0];
  assign final_frame = !job_r.multi || (frame_r == 3'd7);
  assign chip_hit  = (CMP_W'(chip_r) == CMP_W'(job_r.device));

  always_comb begin
    new_data = job_r.data;
    new_reg  = 4'({1'b0, row} + 4'd1);
    case (job_r.op)
      lmcd_pkg::OP_LED:   new_data = led_on ? (old_row | mask) : (old_row & ~mask);
      lmcd_pkg::OP_ROW:   new_data = job_r.data;
      lmcd_pkg::OP_CLEAR: new_data = 8'd0;
      default: begin
        new_data = job_r.data;
        new_reg  = job_r.reg_code;
      end
    endcase
  end

  assign ram_we = (state_r == S_MERGE) && (job_r.op != lmcd_pkg::OP_PLAIN);
  assign pop    = (state_r == S_IDLE) && !q_status.empty;

  lmcd_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_shadow (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (new_data),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    frame_nxt = frame_r;
    chip_nxt  = chip_r;
    unique case (state_r)
      S_IDLE: begin
        if (!q_status.empty) begin
          state_nxt = S_FETCH;
          frame_nxt = 3'd0;
        end
      end
      S_FETCH: begin
        state_nxt = S_MERGE;
      end
      S_MERGE: begin
        state_nxt = S_EMIT;
        chip_nxt  = CNT_W'(chain_len - 1'b1);
      end
      S_EMIT: begin
        if (chip_r == '0) begin
          if (final_frame) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_FETCH;
            frame_nxt = frame_r + 3'd1;
          end
        end else begin
          chip_nxt = chip_r - 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      frame_r     <= 3'd0;
      chip_r      <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      frame_r     <= frame_nxt;
      chip_r      <= chip_nxt;
      out_valid_r <= (state_r == S_EMIT);
      if (ram_we) begin
        valid_r[addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= q_job;
    end
    if (state_r == S_FETCH) begin
      rd_valid_r <= valid_r[addr];
    end
    if (state_r == S_MERGE) begin
      word_r <= {new_reg, 4'h0, new_data} & 16'h0FFF | {4'h0, new_reg, new_data};
    end
    out_data_r.chain_word <= chip_hit ? word_r : 16'd0;
    out_data_r.frame_end  <= (chip_r == '0);
    out_data_r.last       <= (chip_r == '0) && final_frame;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/core/led_matrix_chain_frame_driver_top.sv
// top level of the led matrix chain frame driver
//
//  channel  ports                          handshake
//  in       start, busy, in_data           taken when start and not busy
//  out      out_valid, out_data            one word per strobe, no stall
//  cfg      cfg_valid, cfg_ready, cfg_data written when valid and ready
//
// each frame in the frame engine is a shadow read, a merge and write,
// then one word per chip; column and clear give 8 frames.
// busy rises only when the two-entry job queue is full.
// reset empties the queue and marks every shadow row as zero.
// out has no back pressure; cfg_ready is always high.
`timescale 1ns / 1ps
module led_matrix_chain_frame_driver_top #(
  parameter int MAX_CHIPS = lmcd_pkg::MAX_CHIPS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  lmcd_pkg::in_word_t  in_data,
  output logic                out_valid,
  output lmcd_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [3:0]          cfg_data
);

  localparam int CNT_W = $clog2(MAX_CHIPS + 1);

  logic [3:0]          dev_count_r;
  logic [CNT_W-1:0]    chain_len;
  logic                push;
  logic                pop;
  lmcd_pkg::job_t      push_job;
  lmcd_pkg::job_t      pop_job;
  lmcd_pkg::q_status_t q_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_count_r <= lmcd_pkg::DEV_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      dev_count_r <= cfg_data;
    end
  end

  // zero or too many chips falls back to the full chain
  assign chain_len = ((dev_count_r == 4'd0) || (32'(dev_count_r) > MAX_CHIPS)) ?
                     CNT_W'(MAX_CHIPS) : CNT_W'(dev_count_r);

  lmcd_front #(
    .CNT_W (CNT_W)
  ) u_front (
    .in_data   (in_data),
    .start     (start),
    .chain_len (chain_len),
    .q_status  (q_status),
    .busy      (busy),
    .push      (push),
    .job       (push_job)
  );

  lmcd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .q_status (q_status)
  );

  lmcd_back #(
    .MAX_CHIPS (MAX_CHIPS),
    .CNT_W     (CNT_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .chain_len (chain_len),
    .q_status  (q_status),
    .q_job     (pop_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |-> out_data.frame_end)
    else $error("last word without frame end");

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |=> !out_valid)
    else $error("word right after final word");

  a_frame_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.frame_end |=> out_valid)
    else $error("frame broken up");

  a_busy_blocks_push: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !push)
    else $error("job pushed while queue full");

endmodule
